[rtl/core/hcap_pkg.sv]
// Package for the Hall-count actuator positioner.
// Holds command, direction and register codes plus fixed field widths.
// No dependencies; every other file of the block imports it.
package hcap_pkg;

	localparam int CMD_W       = 3;
	localparam int VALUE_W     = 16;
	localparam int DIR_W       = 2;
	localparam int OUT_W       = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int TPU_W      = 24;
	localparam int USABLE_W   = 16;
	localparam int DEADBAND_W = 8;
	localparam int CAL_MS_W   = 16;
	localparam int DEB_MS_W   = 8;
	localparam int ELAPSED_W  = 17;
	localparam int SINCE_W    = 8;
	localparam int TPU_FRAC_W = 16;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [DIR_W-1:0] dir_t;

	localparam cmd_t CMD_TICK    = 3'd0;
	localparam cmd_t CMD_EDGE    = 3'd1;
	localparam cmd_t CMD_LENGTH  = 3'd2;
	localparam cmd_t CMD_PERCENT = 3'd3;
	localparam cmd_t CMD_CALIB   = 3'd4;
	localparam cmd_t CMD_COUNT   = 3'd5;

	localparam dir_t DIR_STOP    = 2'd0;
	localparam dir_t DIR_EXTEND  = 2'd1;
	localparam dir_t DIR_RETRACT = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_TPU      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_USABLE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CAL_MS   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEB_MS   = 3'd4;

	localparam logic [TPU_W-1:0]      TPU_RESET      = 24'd65536;
	localparam logic [USABLE_W-1:0]   USABLE_RESET   = 16'd1000;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd1;
	localparam logic [CAL_MS_W-1:0]   CAL_MS_RESET   = 16'd15000;
	localparam logic [DEB_MS_W-1:0]   DEB_MS_RESET   = 8'd10;

	localparam logic [VALUE_W-1:0]   PERCENT_FULL = 16'd100;
	localparam int                   PCT_W        = 7;
	localparam logic [PCT_W-1:0]     PCT_FULL_7   = 7'd100;
	localparam int                   PCT_PROD_W   = PCT_W + USABLE_W;

	// Exact floor(x / 100) for x below 2^23: x * ceil(2^30 / 100) >> 30.
	localparam int                   DIV100_W     = 24;
	localparam int                   DIV100_SHIFT = 30;
	localparam logic [DIV100_W-1:0]  DIV100_MUL   = 24'd10737419;
	localparam int                   DIV_PROD_W   = PCT_PROD_W + DIV100_W;

	localparam logic [SINCE_W-1:0]   SINCE_MAX    = 8'hFF;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 17'h1FFFF;
	localparam logic [OUT_W-1:0]     OUT_MAX      = 16'hFFFF;

endpackage

[rtl/core/hcap_if.sv]
// Request and result channel interfaces of the actuator positioner.
// Depends on hcap_pkg for the field widths.
interface hcap_cmd_if;
	import hcap_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface hcap_res_if;
	import hcap_pkg::*;

	logic             valid;
	logic             ready;
	logic             extend_relay_n;
	logic             retract_relay_n;
	logic [DIR_W-1:0] drive_direction;
	logic [OUT_W-1:0] turn_count;
	logic [OUT_W-1:0] target_turns;
	logic             calibrating;

	modport source (
		output valid, output extend_relay_n, output retract_relay_n, output drive_direction,
		output turn_count, output target_turns, output calibrating, input ready
	);
	modport sink (
		input valid, input extend_relay_n, input retract_relay_n, input drive_direction,
		input turn_count, input target_turns, input calibrating, output ready
	);
endinterface

[rtl/core/hall_count_actuator_positioner.sv]
// Top level of the Hall-count actuator positioner: control state, target multiplier,
// percent scaling sequencer and the result register.
// Depends on hcap_pkg and the interfaces in hcap_if.sv.
//
//   port       | kind               | direction | carries
//   -----------+--------------------+-----------+------------------------------------------
//   cmd        | valid/ready stream | in        | command, value
//   res        | valid/ready stream | out       | relays, direction, count, target, calib
//   cfg_*      | write port         | in        | cfg_we, cfg_index, cfg_wdata
//
// Tick, Hall edge, calibrate, set count and unused commands may follow one another
// in every cycle unless requests are held off. Set length loads the length register,
// whose result then passes the target multiplier; set percent first passes the scaling
// multiplier and the divide by 100. No request is taken until that result is formed.
// After a configuration write the request side is held off while the target register
// picks up the new scale. Reset is asynchronous and restores all registers but the
// percent product and the result data; a request is taken while the result register is
// empty or its result leaves at the same edge, and a stalled result holds requests off.
module hall_count_actuator_positioner #(
	parameter int COUNT_WIDTH  = 16,
	parameter int LENGTH_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hcap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hcap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	hcap_cmd_if.sink                         cmd,
	hcap_res_if.source                       res
);
	import hcap_pkg::*;

	localparam int PROD_W    = LENGTH_WIDTH + TPU_W;
	localparam int SHIFT_W   = PROD_W - TPU_FRAC_W;
	localparam int TGT_EXT_W = (SHIFT_W > COUNT_WIDTH) ? SHIFT_W : COUNT_WIDTH;
	localparam int CNT_EXT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
	localparam int LEN_EXT_W = (LENGTH_WIDTH > VALUE_W) ? LENGTH_WIDTH : VALUE_W;

	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_DIV  = 2'd1;
	localparam logic [1:0] SEQ_TGT  = 2'd2;

	// Configuration registers.
	logic [TPU_W-1:0]      tpu_q;
	logic [USABLE_W-1:0]   usable_q;
	logic [DEADBAND_W-1:0] db_q;
	logic [CAL_MS_W-1:0]   cal_ms_q;
	logic [DEB_MS_W-1:0]   deb_ms_q;
	logic                  cfg_hold_q;

	// Control state.
	logic [COUNT_WIDTH-1:0]  cnt_q;
	dir_t                    dir_q;
	logic [LENGTH_WIDTH-1:0] length_q;
	logic                    calib_q;
	logic [ELAPSED_W-1:0]    elapsed_q;
	logic [SINCE_W-1:0]      since_q;
	logic [COUNT_WIDTH-1:0]  target_q;
	logic [PCT_PROD_W-1:0]   pct_prod_q;
	logic [1:0]              seq_q;

	// Result register.
	logic                    res_valid_q;
	logic                    ext_n_q;
	logic                    ret_n_q;
	dir_t                    drive_q;
	logic [OUT_W-1:0]        turn_q;
	logic [OUT_W-1:0]        tgt_out_q;
	logic                    calib_out_q;

	logic                    accept;
	logic                    res_free;
	logic                    load_item;
	logic                    load_tgt;

	logic [COUNT_WIDTH-1:0]  cnt_d;
	dir_t                    dir_d;
	logic [LENGTH_WIDTH-1:0] length_set;
	logic                    calib_d;
	logic [ELAPSED_W-1:0]    elapsed_d;
	logic [SINCE_W-1:0]      since_d;
	dir_t                    ctl_dir;

	logic [PROD_W-1:0]       tgt_prod;
	logic [TGT_EXT_W-1:0]    tgt_shift_ext;
	logic [TGT_EXT_W-1:0]    tgt_max_ext;
	logic [COUNT_WIDTH-1:0]  target_next;

	logic [CNT_EXT_W-1:0]    cnt_max_ext;
	logic [CNT_EXT_W-1:0]    value_cnt_ext;
	logic [COUNT_WIDTH-1:0]  count_set;

	logic [VALUE_W-1:0]      len_clip;
	logic [LEN_EXT_W-1:0]    len_max_ext;
	logic [LEN_EXT_W-1:0]    len_clip_ext;
	logic [LEN_EXT_W-1:0]    len_div_ext;
	logic [PCT_W-1:0]        pct;
	logic [DIV_PROD_W-1:0]   div_prod;
	logic [LENGTH_WIDTH-1:0] length_div;

	logic [COUNT_WIDTH-1:0]  diff_up;
	logic [COUNT_WIDTH-1:0]  diff_dn;
	logic [COUNT_WIDTH-1:0]  db_ext;

	dir_t                    src_dir;
	logic [COUNT_WIDTH-1:0]  src_cnt;
	logic [COUNT_WIDTH-1:0]  src_tgt;
	logic                    src_calib;
	logic [CNT_EXT_W-1:0]    src_cnt_ext;
	logic [TGT_EXT_W-1:0]    src_tgt_ext;

	assign res_free  = !res_valid_q || res.ready;
	assign cmd.ready = (seq_q == SEQ_IDLE) && !cfg_hold_q && res_free;
	assign accept    = cmd.valid && cmd.ready;
	assign load_item = accept && (cmd.command != CMD_LENGTH) && (cmd.command != CMD_PERCENT);
	assign load_tgt  = (seq_q == SEQ_TGT) && res_free;

	// Target turns from the stored length; registered before any comparison uses it.
	assign tgt_prod      = PROD_W'(length_q) * PROD_W'(tpu_q);
	assign tgt_shift_ext = TGT_EXT_W'(tgt_prod[PROD_W-1:TPU_FRAC_W]);
	assign tgt_max_ext   = TGT_EXT_W'({COUNT_WIDTH{1'b1}});
	assign target_next   = COUNT_WIDTH'((tgt_shift_ext > tgt_max_ext) ? tgt_max_ext
		: tgt_shift_ext);

	assign cnt_max_ext   = CNT_EXT_W'({COUNT_WIDTH{1'b1}});
	assign value_cnt_ext = CNT_EXT_W'(cmd.value);
	assign count_set     = COUNT_WIDTH'((value_cnt_ext > cnt_max_ext) ? cnt_max_ext
		: value_cnt_ext);

	assign len_clip     = (cmd.value > usable_q) ? usable_q : cmd.value;
	assign len_max_ext  = LEN_EXT_W'({LENGTH_WIDTH{1'b1}});
	assign len_clip_ext = LEN_EXT_W'(len_clip);
	assign length_set   = LENGTH_WIDTH'((len_clip_ext > len_max_ext) ? len_max_ext
		: len_clip_ext);

	assign pct         = (cmd.value > PERCENT_FULL) ? PCT_FULL_7 : cmd.value[PCT_W-1:0];
	assign div_prod    = DIV_PROD_W'(pct_prod_q) * DIV_PROD_W'(DIV100_MUL);
	assign len_div_ext = LEN_EXT_W'(div_prod[DIV100_SHIFT +: VALUE_W]);
	assign length_div  = LENGTH_WIDTH'((len_div_ext > len_max_ext) ? len_max_ext
		: len_div_ext);

	// Deadband comparison of the registered target against the count.
	assign diff_up = target_q - cnt_q;
	assign diff_dn = cnt_q - target_q;
	assign db_ext  = COUNT_WIDTH'(db_q);

	always_comb begin
		priority if ((target_q > cnt_q) && (diff_up > db_ext)) begin
			ctl_dir = DIR_EXTEND;
		end else if ((target_q < cnt_q) && (diff_dn > db_ext)) begin
			ctl_dir = DIR_RETRACT;
		end else begin
			ctl_dir = DIR_STOP;
		end
	end

	always_comb begin
		cnt_d     = cnt_q;
		dir_d     = dir_q;
		calib_d   = calib_q;
		elapsed_d = elapsed_q;
		since_d   = since_q;
		unique case (cmd.command)
			CMD_TICK: begin
				if (since_q != SINCE_MAX) begin
					since_d = since_q + 1'b1;
				end
				if (calib_q && (elapsed_q != ELAPSED_MAX)) begin
					elapsed_d = elapsed_q + 1'b1;
				end
				// The calibration timeout compares the elapsed time after this tick.
				if (!calib_q) begin
					dir_d = ctl_dir;
				end else if (elapsed_d > ELAPSED_W'(cal_ms_q)) begin
					calib_d = 1'b0;
					cnt_d   = '0;
				end
			end
			CMD_EDGE: begin
				if ((since_q > deb_ms_q) || (since_q == SINCE_MAX)) begin
					if ((dir_q == DIR_EXTEND) && (cnt_q != {COUNT_WIDTH{1'b1}})) begin
						cnt_d = cnt_q + 1'b1;
					end else if ((dir_q == DIR_RETRACT) && (cnt_q != '0)) begin
						cnt_d = cnt_q - 1'b1;
					end
					since_d = '0;
				end
			end
			CMD_CALIB: begin
				if (!calib_q) begin
					calib_d   = 1'b1;
					elapsed_d = '0;
					dir_d     = DIR_RETRACT;
				end
			end
			CMD_COUNT: begin
				cnt_d = count_set;
			end
			default: begin
			end
		endcase
	end

	// Result fields come from the new state for requests that load the result directly, and
	// from the held state with the fresh target when a length or percent request completes.
	assign src_dir     = load_tgt ? dir_q : dir_d;
	assign src_cnt     = load_tgt ? cnt_q : cnt_d;
	assign src_tgt     = load_tgt ? target_next : target_q;
	assign src_calib   = load_tgt ? calib_q : calib_d;
	assign src_cnt_ext = CNT_EXT_W'(src_cnt);
	assign src_tgt_ext = TGT_EXT_W'(src_tgt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q      <= TPU_RESET;
			usable_q   <= USABLE_RESET;
			db_q       <= DEADBAND_RESET;
			cal_ms_q   <= CAL_MS_RESET;
			deb_ms_q   <= DEB_MS_RESET;
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TPU:      tpu_q    <= cfg_wdata[TPU_W-1:0];
					CFG_USABLE:   usable_q <= cfg_wdata[USABLE_W-1:0];
					CFG_DEADBAND: db_q     <= cfg_wdata[DEADBAND_W-1:0];
					CFG_CAL_MS:   cal_ms_q <= cfg_wdata[CAL_MS_W-1:0];
					CFG_DEB_MS:   deb_ms_q <= cfg_wdata[DEB_MS_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dir_q     <= DIR_STOP;
			length_q  <= '0;
			calib_q   <= 1'b0;
			elapsed_q <= '0;
			since_q   <= SINCE_MAX;
			target_q  <= '0;
			seq_q     <= SEQ_IDLE;
		end else begin
			target_q <= target_next;
			if (accept) begin
				cnt_q     <= cnt_d;
				dir_q     <= dir_d;
				calib_q   <= calib_d;
				elapsed_q <= elapsed_d;
				since_q   <= since_d;
			end
			unique case (seq_q)
				SEQ_IDLE: begin
					if (accept && (cmd.command == CMD_LENGTH)) begin
						length_q <= length_set;
						seq_q    <= SEQ_TGT;
					end else if (accept && (cmd.command == CMD_PERCENT)) begin
						seq_q <= SEQ_DIV;
					end
				end
				SEQ_DIV: begin
					length_q <= length_div;
					seq_q    <= SEQ_TGT;
				end
				SEQ_TGT: begin
					if (res_free) begin
						seq_q <= SEQ_IDLE;
					end
				end
				default: begin
					seq_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd.command == CMD_PERCENT)) begin
			pct_prod_q <= PCT_PROD_W'(pct) * PCT_PROD_W'(usable_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_item || load_tgt) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item || load_tgt) begin
			ext_n_q     <= (src_dir != DIR_EXTEND);
			ret_n_q     <= (src_dir != DIR_RETRACT);
			drive_q     <= ((src_dir == DIR_EXTEND) || (src_dir == DIR_RETRACT)) ? src_dir
				: DIR_STOP;
			turn_q      <= (src_cnt_ext > CNT_EXT_W'(OUT_MAX)) ? OUT_MAX
				: src_cnt_ext[OUT_W-1:0];
			tgt_out_q   <= (src_tgt_ext > TGT_EXT_W'(OUT_MAX)) ? OUT_MAX
				: src_tgt_ext[OUT_W-1:0];
			calib_out_q <= src_calib;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.extend_relay_n  = ext_n_q;
	assign res.retract_relay_n = ret_n_q;
	assign res.drive_direction = drive_q;
	assign res.turn_count      = turn_q;
	assign res.target_turns    = tgt_out_q;
	assign res.calibrating     = calib_out_q;

endmodule

[rtl/core/hcap_checker.sv]
// Port-level checks for the actuator positioner's result channel.
// Depends on hcap_pkg; bound to hall_count_actuator_positioner at the end of this file.
module hcap_props (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       extend_relay_n,
	input logic                       retract_relay_n,
	input logic [hcap_pkg::DIR_W-1:0] drive_direction,
	input logic [hcap_pkg::OUT_W-1:0] turn_count,
	input logic [hcap_pkg::OUT_W-1:0] target_turns,
	input logic                       calibrating
);
	import hcap_pkg::*;

	// Both relays energized at once would short the motor.
	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (extend_relay_n || retract_relay_n))
		else $error("both relays energized");

	a_relays_match_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((extend_relay_n == (drive_direction != DIR_EXTEND))
			&& (retract_relay_n == (drive_direction != DIR_RETRACT))))
		else $error("relay lines disagree with drive direction");

	// A running recalibration always drives the actuator inward.
	a_calib_retracts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && calibrating) |-> (drive_direction == DIR_RETRACT))
		else $error("calibration without retract");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(drive_direction)
			&& $stable(turn_count) && $stable(target_turns) && $stable(calibrating)))
		else $error("stalled result changed");

endmodule

bind hall_count_actuator_positioner hcap_props u_hcap_props (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.extend_relay_n  (res.extend_relay_n),
	.retract_relay_n (res.retract_relay_n),
	.drive_direction (res.drive_direction),
	.turn_count      (res.turn_count),
	.target_turns    (res.target_turns),
	.calibrating     (res.calibrating)
);

[sim/hcap_checker.sv]
// Checker for the actuator positioner: predicts every result from the accepted
// requests and register writes, and compares it with what the block returns.
// Depends on hcap_pkg and the channel interfaces in hcap_if.sv.
module hcap_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hcap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hcap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	hcap_cmd_if                              cmd,
	hcap_res_if                              res,
	output int                               errors,
	output int                               backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import hcap_pkg::*;

	typedef struct packed {
		logic             ext_n;
		logic             ret_n;
		dir_t             dir;
		logic [OUT_W-1:0] count;
		logic [OUT_W-1:0] target;
		logic             calib;
	} outcome_t;

	// Register copies.
	logic [TPU_W-1:0]      tpu_q16;
	logic [USABLE_W-1:0]   usable_len;
	logic [DEADBAND_W-1:0] deadband;
	logic [CAL_MS_W-1:0]   calib_limit;
	logic [DEB_MS_W-1:0]   debounce;

	// Positioner state.
	logic [OUT_W-1:0]     turns;
	dir_t                 drive;
	logic [VALUE_W-1:0]   req_len;
	logic                 calib_on;
	logic [ELAPSED_W-1:0] calib_run;
	logic [SINCE_W-1:0]   since_edge;

	outcome_t outcomes_due[$];

	function automatic logic [OUT_W-1:0] target_of(logic [VALUE_W-1:0] len);
		logic [VALUE_W+TPU_W-1:0] prod;
		prod = len * tpu_q16;
		return (prod[VALUE_W+TPU_W-1:TPU_FRAC_W] > OUT_MAX) ? OUT_MAX
			: prod[TPU_FRAC_W+OUT_W-1:TPU_FRAC_W];
	endfunction

	function automatic outcome_t advance_positioner(cmd_t op, logic [VALUE_W-1:0] arg);
		logic [OUT_W-1:0]      goal;
		logic [PCT_PROD_W-1:0] scaled;
		outcome_t              o;
		case (op)
			CMD_TICK: begin
				if (since_edge != SINCE_MAX)
					since_edge++;
				if (calib_on && calib_run != ELAPSED_MAX)
					calib_run++;
				if (!calib_on) begin
					goal = target_of(req_len);
					if (goal > turns && goal - turns > deadband)
						drive = DIR_EXTEND;
					else if (goal < turns && turns - goal > deadband)
						drive = DIR_RETRACT;
					else
						drive = DIR_STOP;
				end else if (calib_run > calib_limit) begin
					// The drive keeps retracting until the next tick decides again.
					calib_on = 1'b0;
					turns = '0;
				end
			end
			CMD_EDGE: begin
				if (since_edge > debounce || since_edge == SINCE_MAX) begin
					if (drive == DIR_EXTEND && turns != OUT_MAX)
						turns++;
					else if (drive == DIR_RETRACT && turns != '0)
						turns--;
					since_edge = '0;
				end
			end
			CMD_LENGTH: req_len = (arg > usable_len) ? usable_len : arg;
			CMD_PERCENT: begin
				scaled = ((arg > PERCENT_FULL) ? PERCENT_FULL : arg) * usable_len;
				req_len = VALUE_W'(scaled / PERCENT_FULL);
			end
			CMD_CALIB: begin
				if (!calib_on) begin
					calib_on = 1'b1;
					calib_run = '0;
					drive = DIR_RETRACT;
				end
			end
			CMD_COUNT: turns = arg;
			default: ;
		endcase
		o.ext_n = (drive != DIR_EXTEND);
		o.ret_n = (drive != DIR_RETRACT);
		o.dir = drive;
		o.count = turns;
		o.target = target_of(req_len);
		o.calib = calib_on;
		return o;
	endfunction

	task automatic log_fault(string what, outcome_t want, outcome_t seen);
		errors++;
		if (errors <= 10)
			$display({"%s: expected ext_n=%b ret_n=%b dir=%0d count=%0d target=%0d",
				" calib=%b, got ext_n=%b ret_n=%b dir=%0d count=%0d target=%0d calib=%b"},
				what, want.ext_n, want.ret_n, want.dir, want.count, want.target, want.calib,
				seen.ext_n, seen.ret_n, seen.dir, seen.count, seen.target, seen.calib);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t seen;
		if (!arst_n) begin
			tpu_q16 = TPU_RESET;
			usable_len = USABLE_RESET;
			deadband = DEADBAND_RESET;
			calib_limit = CAL_MS_RESET;
			debounce = DEB_MS_RESET;
			turns = '0;
			drive = DIR_STOP;
			req_len = '0;
			calib_on = 1'b0;
			calib_run = '0;
			since_edge = SINCE_MAX;
			outcomes_due.delete();
			errors = 0;
			backlog <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TPU:      tpu_q16 = cfg_wdata[TPU_W-1:0];
					CFG_USABLE:   usable_len = cfg_wdata[USABLE_W-1:0];
					CFG_DEADBAND: deadband = cfg_wdata[DEADBAND_W-1:0];
					CFG_CAL_MS:   calib_limit = cfg_wdata[CAL_MS_W-1:0];
					CFG_DEB_MS:   debounce = cfg_wdata[DEB_MS_W-1:0];
					default: ;
				endcase
			end
			// Results are checked before this edge's request is predicted, so a
			// result can never be matched with a request taken at the same edge.
			if (res.valid && res.ready) begin
				seen = {res.extend_relay_n, res.retract_relay_n, res.drive_direction,
					res.turn_count, res.target_turns, res.calibrating};
				if (outcomes_due.size() == 0)
					log_fault("unexpected result", '0, seen);
				else if (outcomes_due[0] !== seen)
					log_fault("result mismatch", outcomes_due.pop_front(), seen);
				else
					void'(outcomes_due.pop_front());
			end
			if (cmd.valid && cmd.ready)
				outcomes_due.push_back(advance_positioner(cmd.command, cmd.value));
			backlog <= outcomes_due.size();
		end
	end
endmodule

[sim/tb_top.sv]
// Top of the actuator positioner testbench: clock, reset, register writes and
// request stimulus with random idling on both channels, plus the verdict.
// Depends on hcap_pkg, hcap_if.sv, hcap_checker and the positioner RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hcap_pkg::*;

	localparam cmd_t CMD_SPARE_6 = 3'd6;
	localparam cmd_t CMD_SPARE_7 = 3'd7;
	localparam int   CYCLE_LIMIT = 500000;
	localparam int   PHASE_ITEMS = 205;

	typedef enum logic [1:0] {TAKE_ALL, TAKE_HALF, TAKE_RARE, TAKE_CYCLIC} take_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	int                     errors;
	int                     backlog;
	int                     burst_left;
	int                     sent_total;
	int                     usable_now;
	int                     cycle_count = 0;
	take_mode_t             take_mode = TAKE_ALL;
	int                     take_left = 0;

	hcap_cmd_if cmd_ch ();
	hcap_res_if res_ch ();

	hall_count_actuator_positioner dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.cmd (cmd_ch),
		.res (res_ch)
	);

	hcap_checker chk (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.cmd     (cmd_ch),
		.res     (res_ch),
		.errors,
		.backlog
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The result side switches between randomly chosen stall patterns.
	always @(posedge clk) begin
		if (take_left == 0) begin
			take_mode <= take_mode_t'($urandom_range(3, 0));
			take_left <= $urandom_range(400, 30);
		end else begin
			take_left <= take_left - 1;
		end
		case (take_mode)
			TAKE_ALL:  res_ch.ready <= 1'b1;
			TAKE_HALF: res_ch.ready <= 1'($urandom_range(1, 0));
			TAKE_RARE: res_ch.ready <= ($urandom_range(5, 0) == 0);
			default:   res_ch.ready <= (take_left[2:0] < 3'd5);
		endcase
	end

	// Sends one request; the sender works in bursts with random gaps between them.
	task automatic push_request(input cmd_t op, input logic [VALUE_W-1:0] arg);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.value <= arg;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		sent_total++;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [TPU_W-1:0] tpu, input logic [USABLE_W-1:0] usable,
			input logic [DEADBAND_W-1:0] band, input logic [CAL_MS_W-1:0] cal,
			input logic [DEB_MS_W-1:0] deb);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TPU;
		cfg_wdata <= CFG_DATA_W'(tpu);
		@(posedge clk);
		cfg_index <= CFG_USABLE;
		cfg_wdata <= CFG_DATA_W'(usable);
		@(posedge clk);
		cfg_index <= CFG_DEADBAND;
		cfg_wdata <= CFG_DATA_W'(band);
		@(posedge clk);
		cfg_index <= CFG_CAL_MS;
		cfg_wdata <= CFG_DATA_W'(cal);
		@(posedge clk);
		cfg_index <= CFG_DEB_MS;
		cfg_wdata <= CFG_DATA_W'(deb);
		@(posedge clk);
		cfg_we <= 1'b0;
		usable_now = int'(usable);
	endtask

	function automatic logic [VALUE_W-1:0] pick_length();
		case ($urandom_range(2, 0))
			0: return VALUE_W'($urandom);
			1: return VALUE_W'($urandom_range(64, 0));
			default: return VALUE_W'($urandom_range(usable_now, 0));
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_percent();
		if ($urandom_range(4, 0) == 0)
			return VALUE_W'($urandom);
		return VALUE_W'($urandom_range(110, 0));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_count();
		if ($urandom_range(3, 0) == 0)
			return VALUE_W'($urandom);
		return VALUE_W'($urandom_range(usable_now + 8, 0));
	endfunction

	// Mostly moves: a new target followed by a run of ticks and Hall edges that
	// lets the drive chase it. The rest is noise, including the unused commands.
	task automatic run_moves(input int budget);
		int stop_at;
		int steps;
		stop_at = sent_total + budget;
		while (sent_total < stop_at) begin
			if ($urandom_range(9, 0) == 0) begin
				push_request(cmd_t'($urandom_range(7, 0)), VALUE_W'($urandom));
			end else begin
				if ($urandom_range(1, 0) == 1)
					push_request(CMD_LENGTH, pick_length());
				else
					push_request(CMD_PERCENT, pick_percent());
				if ($urandom_range(7, 0) == 0)
					push_request(CMD_COUNT, pick_count());
				if ($urandom_range(15, 0) == 0)
					push_request(CMD_CALIB, VALUE_W'($urandom));
				steps = $urandom_range(30, 4);
				repeat (steps)
					push_request(($urandom_range(2, 0) == 0) ? CMD_EDGE : CMD_TICK,
						VALUE_W'($urandom));
			end
			if ($urandom_range(120, 0) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.value = '0;
		burst_left = 0;
		sent_total = 0;
		usable_now = int'(USABLE_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with no deadband and no debounce so every case is one step away.
		apply_setting(TPU_RESET, USABLE_RESET, 8'd0, CAL_MS_RESET, 8'd0);
		push_request(CMD_LENGTH, 16'hFFFF);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_EDGE, 16'h0000);
		push_request(CMD_EDGE, 16'hFFFF);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_COUNT, 16'hFFFF);
		push_request(CMD_EDGE, 16'h0000);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_EDGE, 16'h0000);
		push_request(CMD_PERCENT, 16'hFFFF);
		push_request(CMD_PERCENT, 16'h0000);
		push_request(CMD_COUNT, 16'h0000);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_PERCENT, 16'd50);
		push_request(CMD_COUNT, 16'd500);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_SPARE_6, 16'hFFFF);
		push_request(CMD_SPARE_7, 16'h0000);
		push_request(CMD_CALIB, 16'h0000);
		push_request(CMD_CALIB, 16'hFFFF);
		push_request(CMD_COUNT, 16'h0000);
		push_request(CMD_TICK, 16'h0000);
		push_request(CMD_EDGE, 16'h0000);

		// A zero retract time ends the running calibration on the first tick.
		apply_setting(TPU_RESET, USABLE_RESET, DEADBAND_RESET, 16'd0, 8'd0);
		run_moves(PHASE_ITEMS);
		apply_setting(24'hFFFFFF, 16'hFFFF, 8'hFF, 16'd20, 8'd2);
		run_moves(PHASE_ITEMS);
		apply_setting(24'd0, 16'd0, 8'd0, 16'd5, 8'd1);
		run_moves(PHASE_ITEMS);
		apply_setting(TPU_W'($urandom_range(4 * 65536, 1024)), USABLE_W'($urandom),
			DEADBAND_W'($urandom_range(6, 0)), 16'hFFFF, 8'hFF);
		run_moves(PHASE_ITEMS);
		apply_setting(TPU_W'(3 * 65536 + $urandom_range(65535, 0)), 16'hFFFF, 8'd0,
			16'd30, 8'd0);
		run_moves(PHASE_ITEMS);
		apply_setting(TPU_W'($urandom), USABLE_W'($urandom), DEADBAND_W'($urandom),
			CAL_MS_W'($urandom_range(60, 0)), DEB_MS_W'($urandom_range(4, 0)));
		run_moves(PHASE_ITEMS);
		apply_setting(TPU_RESET, USABLE_RESET, DEADBAND_RESET, CAL_MS_RESET, DEB_MS_RESET);
		run_moves(PHASE_ITEMS);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && backlog == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[hall_count_actuator_positioner.f]
rtl/core/hcap_pkg.sv
rtl/core/hcap_if.sv
rtl/core/hall_count_actuator_positioner.sv
rtl/core/hcap_checker.sv
sim/hcap_checker.sv
sim/tb_top.sv
